>>> rtl/core/cbp_pkg.sv
// Package for the code byte packer: sizing constants, segment record and
// stack control types. No dependencies.
package cbp_pkg;

    localparam int MAX_SEGMENTS = 1024;
    localparam int MAX_CODES    = 65536;

    localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int LEN_W  = $clog2(MAX_CODES + 1);

    localparam int CHUNK_W   = 6;
    localparam int CHUNK_MAX = 63;
    localparam int CODE_W    = 32;
    localparam int BYTE_W    = 8;

    typedef struct packed {
        logic [1:0]       size;
        logic [LEN_W-1:0] len;
    } t_seg;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [SEG_AW-1:0] wr_addr;
        logic [SEG_AW-1:0] rd_addr;
        t_seg              wr_data;
    } t_stk_ctl;

endpackage

>>> rtl/core/cbp_seg_stack.sv
// Segment stack: memory of closed runs plus a registered copy of the top
// entry and of the entry below it. Depends on cbp_pkg.
module cbp_seg_stack
    import cbp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_stk_ctl i_ctl,
    output t_seg     o_top
);

    t_seg r_mem [MAX_SEGMENTS];
    t_seg r_below;
    t_seg r_top;
    t_seg n_top;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
        r_below <= r_mem[i_ctl.rd_addr];
    end

    always_comb begin
        n_top = r_top;
        if (i_ctl.push && !i_ctl.pop) begin
            n_top = i_ctl.wr_data;
        end else if (i_ctl.pop && !i_ctl.push) begin
            n_top = r_below;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '0;
        end else begin
            r_top <= n_top;
        end
    end

    assign o_top = r_top;

endmodule

>>> rtl/core/code_byte_packer_with_size_runs.sv
// Top level of the code byte packer with size-run trailer.
// Depends on cbp_pkg and cbp_seg_stack.
//
// Code transfers (tuser 0) give the code's 1 to 4 bytes, least significant
// first, tlast on the final byte; drain transfers (tuser 1) give one trailer
// byte each, newest segment first, or nothing when no segment is recorded.
// An item waits in the input register while its bytes leave through the
// output register, one byte per cycle while the output is not stalled: a
// code item gives its 1 to 4 bytes, a drain item at most one byte, and the
// next item is taken in the cycle the current one finishes. The segment stack
// is a MAX_SEGMENTS-entry memory with its top entry held in registers, so pops
// run at one per cycle without a pause while the output is not stalled.
module code_byte_packer_with_size_runs
    import cbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [CODE_W-1:0] s_axis_tdata,   // code
    input  logic              s_axis_tuser,   // command
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,   // out_byte
    output logic              m_axis_tuser,   // is_trailer
    output logic              m_axis_tlast    // last_of_run
);

    logic              r_in_valid;
    logic              r_cmd;
    logic [CODE_W-1:0] r_code;
    logic [1:0]        r_idx;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_trailer;
    logic              r_out_last;

    logic [1:0]        r_open_size;
    logic [LEN_W-1:0]  r_open_len;
    logic [CNT_W-1:0]  r_count;
    logic              r_draining;
    logic [LEN_W-1:0]  r_remaining;
    logic [1:0]        r_drain_size;

    logic              n_in_valid;
    logic [1:0]        n_idx;
    logic              n_out_valid;
    logic [BYTE_W-1:0] n_out_byte;
    logic              n_out_trailer;
    logic              n_out_last;
    logic [1:0]        n_open_size;
    logic [LEN_W-1:0]  n_open_len;
    logic [CNT_W-1:0]  n_count;
    logic              n_draining;
    logic [LEN_W-1:0]  n_remaining;
    logic [1:0]        n_drain_size;

    logic              in_fire;
    logic              fire;
    t_stk_ctl          stk_ctl;
    t_seg              stk_top;

    cbp_seg_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (stk_ctl),
        .o_top   (stk_top)
    );

    assign in_fire = s_axis_tvalid && s_axis_tready;

    always_comb begin
        logic [1:0]       sm1;
        logic             slot_free;
        logic             push_c;
        logic             push_req;
        logic [CNT_W-1:0] base;
        logic             push_ok;
        logic [CNT_W-1:0] cnt_b;
        logic [CNT_W-1:0] cnt_c;
        logic             need_pop;
        logic             pop_ok;
        logic             emits;
        logic             done;
        t_seg             pushed;
        t_seg             seg;
        logic [LEN_W-1:0] rem_src;
        logic [1:0]       size_src;
        logic [LEN_W-1:0] chunk;
        logic [LEN_W-1:0] rem_n;
        logic             d_last;
        logic [BYTE_W-1:0] code_byte;
        logic [CNT_W-1:0] rd_cnt;

        n_in_valid    = r_in_valid;
        n_idx         = r_idx;
        n_out_valid   = r_out_valid;
        n_out_byte    = r_out_byte;
        n_out_trailer = r_out_trailer;
        n_out_last    = r_out_last;
        n_open_size   = r_open_size;
        n_open_len    = r_open_len;
        n_count       = r_count;
        n_draining    = r_draining;
        n_remaining   = r_remaining;
        n_drain_size  = r_drain_size;

        if (r_code > CODE_W'(32'h00FF_FFFF)) begin
            sm1 = 2'd3;
        end else if (r_code > CODE_W'(32'h0000_FFFF)) begin
            sm1 = 2'd2;
        end else if (r_code > CODE_W'(32'h0000_00FF)) begin
            sm1 = 2'd1;
        end else begin
            sm1 = 2'd0;
        end

        case (r_idx)
            2'd0:    code_byte = r_code[7:0];
            2'd1:    code_byte = r_code[15:8];
            2'd2:    code_byte = r_code[23:16];
            2'd3:    code_byte = r_code[31:24];
            default: code_byte = r_code[7:0];
        endcase

        slot_free = !r_out_valid || m_axis_tready;

        push_c   = (r_open_len != '0) &&
                   ((r_open_size != sm1) || (r_open_len >= LEN_W'(MAX_CODES)));
        push_req = r_cmd ? (!r_draining && (r_open_len != '0)) : push_c;
        base     = (!r_cmd && r_draining) ? '0 : r_count;
        push_ok  = push_req && (base < CNT_W'(MAX_SEGMENTS));
        cnt_b    = push_ok ? base + CNT_W'(1) : base;

        pushed.size = r_open_size;
        pushed.len  = r_open_len;

        need_pop = !r_draining || (r_remaining == '0);
        pop_ok   = need_pop && (cnt_b != '0);
        emits    = r_cmd ? (!need_pop || pop_ok) : 1'b1;
        cnt_c    = pop_ok ? cnt_b - CNT_W'(1) : cnt_b;
        seg      = push_ok ? pushed : stk_top;
        rem_src  = need_pop ? seg.len : r_remaining;
        size_src = need_pop ? seg.size : r_drain_size;
        chunk    = (rem_src > LEN_W'(CHUNK_MAX)) ? LEN_W'(CHUNK_MAX) : rem_src;
        rem_n    = rem_src - chunk;
        d_last   = (rem_n == '0) && (cnt_c == '0);

        done = r_cmd || (r_idx == sm1);
        fire = r_in_valid && slot_free && done;

        if (slot_free) begin
            n_out_valid = r_in_valid && emits;
            if (r_cmd) begin
                n_out_byte    = {size_src, chunk[CHUNK_W-1:0]};
                n_out_trailer = 1'b1;
                n_out_last    = d_last;
            end else begin
                n_out_byte    = code_byte;
                n_out_trailer = 1'b0;
                n_out_last    = (r_idx == sm1);
            end
            if (r_in_valid && !r_cmd) begin
                n_idx = (r_idx == sm1) ? 2'd0 : r_idx + 2'd1;
            end
        end

        if (fire) begin
            if (r_cmd) begin
                if (!r_draining) begin
                    n_open_len  = '0;
                    n_open_size = 2'd0;
                end
                if (emits) begin
                    n_draining   = !d_last;
                    n_remaining  = rem_n;
                    n_drain_size = size_src;
                    n_count      = cnt_c;
                end else begin
                    n_draining = 1'b0;
                    n_count    = cnt_b;
                end
            end else begin
                n_draining  = 1'b0;
                n_remaining = '0;
                n_count     = cnt_b;
                n_open_size = sm1;
                n_open_len  = push_c ? LEN_W'(1) : r_open_len + LEN_W'(1);
            end
        end

        if (in_fire) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end

        rd_cnt          = n_count - CNT_W'(2);
        stk_ctl.push    = fire && push_ok;
        stk_ctl.pop     = fire && r_cmd && pop_ok;
        stk_ctl.wr_addr = base[SEG_AW-1:0];
        stk_ctl.rd_addr = rd_cnt[SEG_AW-1:0];
        stk_ctl.wr_data = pushed;
    end

    assign s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd  <= s_axis_tuser;
            r_code <= s_axis_tdata;
        end
        r_out_byte    <= n_out_byte;
        r_out_trailer <= n_out_trailer;
        r_out_last    <= n_out_last;
        r_drain_size  <= n_drain_size;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
            r_open_size <= 2'd0;
            r_open_len  <= '0;
            r_count     <= '0;
            r_draining  <= 1'b0;
            r_remaining <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            r_open_size <= n_open_size;
            r_open_len  <= n_open_len;
            r_count     <= n_count;
            r_draining  <= n_draining;
            r_remaining <= n_remaining;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = r_out_trailer;
    assign m_axis_tlast  = r_out_last;

endmodule

>>> tb/tb_code_byte_packer_with_size_runs.sv
// Self-checking testbench for code_byte_packer_with_size_runs: directed rows and random
// sequences, scored against a behavioural predictor.
// Depends on cbp_pkg and the RTL of the packer.
module tb_code_byte_packer_with_size_runs;
    import cbp_pkg::*;

    localparam bit CMD_CODE  = 1'b0;
    localparam bit CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic [7:0] data;
        logic       trl;
        logic       lst;
    } t_byte_res;

    typedef struct {
        bit               cmd;
        logic [31:0]      code;
        int               n_typed;   // -1: take the predictor
        t_byte_res [3:0]  typed;
    } t_stim_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [CODE_W-1:0] s_axis_tdata;   // code
    logic              s_axis_tuser;   // command
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [BYTE_W-1:0] m_axis_tdata;   // out_byte
    logic              m_axis_tuser;   // is_trailer
    logic              m_axis_tlast;   // last_of_run

    code_byte_packer_with_size_runs i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // packer state as predicted
    logic [1:0]  mdl_open_size = '0;
    int unsigned mdl_open_len  = 0;
    t_seg        mdl_stack [MAX_SEGMENTS];
    int unsigned mdl_stk_cnt   = 0;
    bit          mdl_draining  = 1'b0;
    int unsigned mdl_drn_rem   = 0;
    logic [1:0]  mdl_drn_size  = '0;

    t_byte_res   step_out [$];
    t_byte_res   pending_bytes [$];
    t_byte_res   want;
    t_stim_row   stim_rows [$];
    bit          idle_on   = 1'b1;
    int          rdy_wait  = 0;
    int          n_errors  = 0;
    int          n_sent    = 0;

    function automatic t_byte_res mk_byte(logic [7:0] d, logic trl, logic lst);
        t_byte_res r;
        r.data = d;
        r.trl  = trl;
        r.lst  = lst;
        return r;
    endfunction

    function automatic t_stim_row mk_row(bit cmd, logic [31:0] code, int n,
                                         t_byte_res r0, t_byte_res r1,
                                         t_byte_res r2, t_byte_res r3);
        t_stim_row row;
        row.cmd      = cmd;
        row.code     = code;
        row.n_typed  = n;
        row.typed[0] = r0;
        row.typed[1] = r1;
        row.typed[2] = r2;
        row.typed[3] = r3;
        return row;
    endfunction

    function automatic void add_row(t_stim_row row);
        stim_rows = {stim_rows, row};
    endfunction

    function automatic logic [31:0] rand_code(int sz);
        case (sz)
            0:       return $urandom_range(0, 32'h0000_00FF);
            1:       return $urandom_range(32'h0000_0100, 32'h0000_FFFF);
            2:       return $urandom_range(32'h0001_0000, 32'h00FF_FFFF);
            default: return $urandom_range(32'h0100_0000, 32'hFFFF_FFFF);
        endcase
    endfunction

    function automatic void close_open_run();
        if (mdl_open_len != 0 && mdl_stk_cnt < MAX_SEGMENTS) begin
            mdl_stack[mdl_stk_cnt].size = mdl_open_size;
            mdl_stack[mdl_stk_cnt].len  = LEN_W'(mdl_open_len);
            mdl_stk_cnt++;
        end
        mdl_open_len = 0;
    endfunction

    function automatic void pack_model_step(bit cmd, logic [31:0] code);
        int unsigned nb;
        logic [1:0]  sm1;
        int unsigned chunk;
        bit          lst;
        step_out.delete();
        if (cmd == CMD_CODE) begin
            if (mdl_draining) begin
                mdl_draining = 1'b0;
                mdl_drn_rem  = 0;
                mdl_stk_cnt  = 0;
            end
            nb  = (code > 32'h00FF_FFFF) ? 4 : (code > 32'h0000_FFFF) ? 3 :
                  (code > 32'h0000_00FF) ? 2 : 1;
            sm1 = 2'(nb - 1);
            if (mdl_open_len != 0 && (mdl_open_size != sm1 || mdl_open_len >= MAX_CODES))
                close_open_run();
            mdl_open_size = sm1;
            mdl_open_len++;
            for (int i = 0; i < nb; i++)
                step_out = {step_out, mk_byte(code[8*i +: 8], 1'b0, i == nb - 1)};
            return;
        end
        if (!mdl_draining) begin
            close_open_run();
            mdl_open_size = '0;
            if (mdl_stk_cnt == 0)
                return;
            mdl_draining = 1'b1;
            mdl_drn_rem  = 0;
        end
        if (mdl_drn_rem == 0) begin
            if (mdl_stk_cnt == 0) begin
                mdl_draining = 1'b0;
                return;
            end
            mdl_stk_cnt--;
            mdl_drn_size = mdl_stack[mdl_stk_cnt].size;
            mdl_drn_rem  = mdl_stack[mdl_stk_cnt].len;
        end
        chunk = (mdl_drn_rem > CHUNK_MAX) ? CHUNK_MAX : mdl_drn_rem;
        mdl_drn_rem -= chunk;
        lst = (mdl_drn_rem == 0 && mdl_stk_cnt == 0);
        step_out = {step_out, mk_byte({mdl_drn_size, 6'(chunk)}, 1'b1, lst)};
        if (lst)
            mdl_draining = 1'b0;
    endfunction

    task automatic drive_item(input bit cmd, input logic [31:0] code, input int n_typed,
                              input t_byte_res [3:0] typed);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= code;
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
        pack_model_step(cmd, code);
        if (n_typed < 0) begin
            foreach (step_out[i])
                pending_bytes = {pending_bytes, step_out[i]};
        end else begin
            for (int i = 0; i < n_typed; i++)
                pending_bytes = {pending_bytes, typed[i]};
        end
    endtask

    // drain until the predicted packer holds nothing
    task automatic drain_all();
        while (mdl_open_len != 0 || mdl_stk_cnt != 0 || mdl_draining)
            drive_item(CMD_DRAIN, $urandom, -1, '0);
    endtask

    initial begin : out_stall
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rdy_wait > 0) begin
                m_axis_tready <= 1'b0;
                rdy_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            rdy_wait = idle_on ? $urandom_range(0, 11) : 0;
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected transfer, got byte %h trailer %b last %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                n_errors++;
            end else begin
                want = pending_bytes.pop_front();
                if (m_axis_tdata !== want.data) begin
                    $display("%0t: out_byte expected %h got %h", $time, want.data, m_axis_tdata);
                    n_errors++;
                end
                if (m_axis_tuser !== want.trl) begin
                    $display("%0t: is_trailer expected %b got %b", $time, want.trl, m_axis_tuser);
                    n_errors++;
                end
                if (m_axis_tlast !== want.lst) begin
                    $display("%0t: last_of_run expected %b got %b", $time, want.lst, m_axis_tlast);
                    n_errors++;
                end
            end
        end
    end

    initial begin : stim
        t_byte_res nb;
        int        sz;
        int        run;
        int        kind;
        nb = '0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_CODE;

        add_row(mk_row(CMD_DRAIN, 32'h0, 0, nb, nb, nb, nb));
        add_row(mk_row(CMD_CODE, 32'h0, 1, mk_byte(8'h00, 0, 1), nb, nb, nb));
        add_row(mk_row(CMD_DRAIN, 32'h0, 1, mk_byte(8'h01, 1, 1), nb, nb, nb));
        add_row(mk_row(CMD_DRAIN, 32'hFFFF_FFFF, 0, nb, nb, nb, nb));
        add_row(mk_row(CMD_CODE, 32'hFFFF_FFFF, 4, mk_byte(8'hFF, 0, 0),
                       mk_byte(8'hFF, 0, 0), mk_byte(8'hFF, 0, 0),
                       mk_byte(8'hFF, 0, 1)));
        add_row(mk_row(CMD_CODE, 32'h0000_00FF, 1, mk_byte(8'hFF, 0, 1),
                       nb, nb, nb));
        add_row(mk_row(CMD_CODE, 32'h0000_0100, 2, mk_byte(8'h00, 0, 0),
                       mk_byte(8'h01, 0, 1), nb, nb));
        add_row(mk_row(CMD_CODE, 32'h0000_FFFF, 2, mk_byte(8'hFF, 0, 0),
                       mk_byte(8'hFF, 0, 1), nb, nb));
        add_row(mk_row(CMD_CODE, 32'h0001_0000, 3, mk_byte(8'h00, 0, 0),
                       mk_byte(8'h00, 0, 0), mk_byte(8'h01, 0, 1), nb));
        add_row(mk_row(CMD_CODE, 32'h00FF_FFFF, 3, mk_byte(8'hFF, 0, 0),
                       mk_byte(8'hFF, 0, 0), mk_byte(8'hFF, 0, 1), nb));
        add_row(mk_row(CMD_CODE, 32'h0100_0000, 4, mk_byte(8'h00, 0, 0),
                       mk_byte(8'h00, 0, 0), mk_byte(8'h00, 0, 0),
                       mk_byte(8'h01, 0, 1)));
        add_row(mk_row(CMD_DRAIN, 32'h0, 1, mk_byte(8'hC1, 1, 0), nb, nb, nb));
        add_row(mk_row(CMD_DRAIN, 32'h0, 1, mk_byte(8'h82, 1, 0), nb, nb, nb));
        // code in mid-drain abandons the remaining segments
        add_row(mk_row(CMD_CODE, 32'h1234_5678, 4, mk_byte(8'h78, 0, 0),
                       mk_byte(8'h56, 0, 0), mk_byte(8'h34, 0, 0),
                       mk_byte(8'h12, 0, 1)));
        add_row(mk_row(CMD_DRAIN, 32'h0, 1, mk_byte(8'hC1, 1, 1), nb, nb, nb));
        add_row(mk_row(CMD_CODE, 32'h0000_00A5, 1, mk_byte(8'hA5, 0, 1),
                       nb, nb, nb));
        add_row(mk_row(CMD_CODE, 32'h0000_005A, 1, mk_byte(8'h5A, 0, 1),
                       nb, nb, nb));
        add_row(mk_row(CMD_DRAIN, 32'h0, 1, mk_byte(8'h02, 1, 1), nb, nb, nb));
        add_row(mk_row(CMD_CODE, 32'h8000_0000, -1, nb, nb, nb, nb));
        add_row(mk_row(CMD_CODE, 32'h0000_8000, -1, nb, nb, nb, nb));
        add_row(mk_row(CMD_CODE, 32'h0080_0000, -1, nb, nb, nb, nb));
        add_row(mk_row(CMD_DRAIN, 32'h5555_AAAA, -1, nb, nb, nb, nb));
        add_row(mk_row(CMD_CODE, 32'h0000_0001, -1, nb, nb, nb, nb));
        add_row(mk_row(CMD_DRAIN, 32'hAAAA_5555, -1, nb, nb, nb, nb));
        add_row(mk_row(CMD_DRAIN, 32'h0, -1, nb, nb, nb, nb));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[i])
            drive_item(stim_rows[i].cmd, stim_rows[i].code, stim_rows[i].n_typed,
                       stim_rows[i].typed);

        while (n_sent < 100) begin
            idle_on = ($urandom_range(0, 3) != 0);
            kind    = $urandom_range(0, 9);
            if (kind < 6) begin
                repeat ($urandom_range(1, 4)) begin
                    sz  = $urandom_range(0, 3);
                    run = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 70)
                                                      : $urandom_range(1, 5);
                    repeat (run)
                        drive_item(CMD_CODE, rand_code(sz), -1, '0);
                end
                drain_all();
                if ($urandom_range(0, 3) == 0)
                    drive_item(CMD_DRAIN, $urandom, -1, '0);
            end else if (kind < 8) begin
                repeat ($urandom_range(1, 6))
                    drive_item(CMD_CODE, rand_code($urandom_range(0, 3)), -1, '0);
                repeat ($urandom_range(1, 2))
                    drive_item(CMD_DRAIN, $urandom, -1, '0);
            end else begin
                repeat ($urandom_range(1, 4))
                    drive_item(1'($urandom_range(0, 1)), $urandom, -1, '0);
            end
        end
        drain_all();

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
